FILE: hw/rtl/tcs_pkg.sv
// Shared types and constants for the tone cadence sequencer.
// No dependencies; every other file in hw/rtl imports this package.
package tcs_pkg;

    localparam int ITEM_W           = 5;
    localparam int MAX_ITEMS        = 1 << ITEM_W;
    localparam int MAX_TICK_SAMPLES = 1999;
    localparam int FREQ_W           = 16;
    localparam int DUR_W            = 16;
    localparam int DEPTH_W          = 7;
    localparam int DEPTH_MAX        = 100;
    localparam int TICK_W           = 12;
    localparam int POS_W            = 20;
    localparam int MS_SHIFT         = 3;   // 8 samples per millisecond
    localparam int LEVEL_W          = 7;
    localparam int REPEAT_W         = 6;
    localparam int COUNT_W          = 6;
    localparam int CMD_W            = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 7;
    localparam int S_TDATA_W        = 80;
    localparam int M_TDATA_W        = 56;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_TONE_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INDEX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT   = 2'd2;

    // One tone table entry (56 bits)
    typedef struct packed {
        logic [FREQ_W-1:0]  first_freq;
        logic [FREQ_W-1:0]  second_freq;
        logic [DUR_W-1:0]   duration_ms;
        logic               modulate_flag;
        logic [DEPTH_W-1:0] mod_depth;
    } tone_entry_t;

    // Input beat fields, last member at the lowest bits
    typedef struct packed {
        logic [TICK_W-1:0]  tick_samples;
        logic [DEPTH_W-1:0] mod_depth;
        logic               modulate_flag;
        logic [DUR_W-1:0]   duration_ms;
        logic [FREQ_W-1:0]  second_freq;
        logic [FREQ_W-1:0]  first_freq;
        logic [ITEM_W-1:0]  item_index;
    } in_fields_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        in_fields_t       f;
    } in_item_t;

    // Result beat fields, last member at the lowest bits
    typedef struct packed {
        logic                      tick_too_long;
        logic                      finished;
        logic                      item_changed;
        logic signed [LEVEL_W-1:0] level_out;
        logic [DEPTH_W-1:0]        depth_percent;
        logic                      modulated;
        logic [FREQ_W-1:0]         other_freq;
        logic [FREQ_W-1:0]         main_freq;
        logic [ITEM_W-1:0]         playing_index;
    } out_item_t;

    typedef struct packed {
        logic [REPEAT_W-1:0] repeat_index;
        logic [COUNT_W-1:0]  item_count;
    } seq_cfg_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ITEM_W-1:0] addr;
        tone_entry_t       wdata;
    } ram_req_t;

    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic              changed;
        logic              done;
        logic              too_long;
    } seq_status_t;

endpackage

FILE: hw/rtl/tone_cadence_sequencer.sv
// Top level of the tone cadence sequencer: ports, configuration registers,
// result formatting and output register. Depends on tcs_pkg, tcs_seq, tcs_table_ram.
//
//  channel   dir  width        contents
//  s_*       in   80 + 2 user  one command beat (load, start, tick)
//  m_*       out  56           one status beat per command
//  cfg_*     in   2 idx, 7 dat register write, no read-back
//
// A command beat passes through EXEC, READ and OUT before the next accept (load,
// start, ignored tick); a tick that runs adds TICK after EXEC. The single table port
// sets this, since a tick reads the sounding entry, updates, then reads the entry
// now sounding. The status beat turns valid as the sequencer leaves OUT for idle,
// in the same cycle that s_tready rises again.
// Reset is synchronous on aresetn low; the tone table is not cleared.
// A stalled m_tready holds the result; one further command may be accepted and
// worked up to its final step meanwhile.
module tone_cadence_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // item_index, first_freq, second_freq, duration_ms, modulate_flag,
    // mod_depth, tick_samples, zero pad
    input  logic [tcs_pkg::S_TDATA_W-1:0]       s_tdata,
    // cmd
    input  logic [tcs_pkg::CMD_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // playing_index, main_freq, other_freq, modulated, depth_percent,
    // level_out, item_changed, finished, tick_too_long, zero pad
    output logic [tcs_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tcs_pkg::*;

    logic signed [LEVEL_W-1:0] tone_level_reg;
    logic [REPEAT_W-1:0]       repeat_index_reg;
    logic [COUNT_W-1:0]        item_count_reg;

    in_item_t    in_item;
    seq_cfg_t    seq_cfg;
    ram_req_t    ram_req;
    tone_entry_t rd_entry;
    seq_status_t status;
    logic        emit;
    logic        out_free;

    out_item_t                 out_next;
    out_item_t                 out_reg;
    logic                      m_tvalid_reg;
    logic signed [LEVEL_W-1:0] level_sat;

    // configuration writes; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_level_reg   <= -LEVEL_W'(13);
            repeat_index_reg <= {REPEAT_W{1'b1}};
            item_count_reg   <= COUNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TONE_LEVEL:   tone_level_reg   <= cfg_data[LEVEL_W-1:0];
                REG_REPEAT_INDEX: repeat_index_reg <= cfg_data[REPEAT_W-1:0];
                REG_ITEM_COUNT:   item_count_reg   <= cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.cmd = cmd_t'(s_tuser);
    assign in_item.f   = s_tdata[$bits(in_fields_t)-1:0];
    assign seq_cfg     = '{repeat_index: repeat_index_reg, item_count: item_count_reg};

    tcs_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .cfg      (seq_cfg),
        .rd_entry (rd_entry),
        .ram_req  (ram_req),
        .out_free (out_free),
        .emit     (emit),
        .status   (status)
    );

    tcs_table_ram u_table (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (rd_entry)
    );

    // level: clamp non-negative to 0 and the most negative code to -63
    always_comb begin
        if (!tone_level_reg[LEVEL_W-1]) begin
            level_sat = '0;
        end else if (tone_level_reg == {1'b1, {(LEVEL_W-1){1'b0}}}) begin
            level_sat = -LEVEL_W'(63);
        end else begin
            level_sat = tone_level_reg;
        end
    end

    // format the entry now sounding; modulated items put the higher tone first
    always_comb begin
        out_next               = '0;
        out_next.playing_index = status.item;
        out_next.level_out     = level_sat;
        out_next.item_changed  = status.changed;
        out_next.finished      = status.done;
        out_next.tick_too_long = status.too_long;
        if (rd_entry.modulate_flag) begin
            out_next.modulated     = 1'b1;
            out_next.depth_percent = rd_entry.mod_depth;
            if (rd_entry.first_freq > rd_entry.second_freq) begin
                out_next.main_freq  = rd_entry.first_freq;
                out_next.other_freq = rd_entry.second_freq;
            end else begin
                out_next.main_freq  = rd_entry.second_freq;
                out_next.other_freq = rd_entry.first_freq;
            end
        end else begin
            out_next.main_freq  = rd_entry.first_freq;
            out_next.other_freq = rd_entry.second_freq;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // output register: load on emit, drop valid once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

    // a rejected tick never moves to a new item
    a_changed_excl_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(out_reg.item_changed && out_reg.tick_too_long))
        else $error("result reports both item change and long tick");

    a_mod_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_reg.modulated) |-> (out_reg.main_freq >= out_reg.other_freq))
        else $error("modulated carrier below modulator");

    a_plain_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !out_reg.modulated) |-> (out_reg.depth_percent == '0))
        else $error("plain tone reports nonzero depth");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command accepted while one is in work");

endmodule

FILE: hw/rtl/tcs_table_ram.sv
// Tone table storage: single-port synchronous RAM with a registered read.
// Depends on tcs_pkg for the entry type and request struct.
module tcs_table_ram (
    input  logic                 aclk,
    input  tcs_pkg::ram_req_t    req,
    output tcs_pkg::tone_entry_t rd_data
);
    import tcs_pkg::*;

    tone_entry_t table_mem [MAX_ITEMS];
    tone_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            table_mem[req.addr] <= req.wdata;
        end
        // hold read data when no read is issued
        if (req.re) begin
            rd_data_reg <= table_mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/tcs_seq.sv
// Sequencer control: command decode, table writes and reads, cadence stepping.
// Depends on tcs_pkg; drives tcs_table_ram through a request struct.
module tcs_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcs_pkg::in_item_t    in_item,
    input  tcs_pkg::seq_cfg_t    cfg,
    input  tcs_pkg::tone_entry_t rd_entry,
    output tcs_pkg::ram_req_t    ram_req,
    input  logic                 out_free,
    output logic                 emit,
    output tcs_pkg::seq_status_t status
);
    import tcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_READ,
        ST_OUT
    } state_t;

    state_t            state_reg;
    in_item_t          item_reg;
    logic [ITEM_W-1:0] cur_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              done_reg;
    logic              changed_reg;
    logic              too_long_reg;

    logic                tick_long;
    logic [POS_W:0]      pos_sum;
    logic [POS_W-1:0]    pos_sat;
    logic [POS_W-1:0]    dur_samples;
    logic                hit;
    logic [COUNT_W-1:0]  eff_cnt;
    logic [COUNT_W-1:0]  nxt_inc;
    logic                wrap;
    logic                stop;
    logic [ITEM_W-1:0]   rep_item;
    logic [ITEM_W-1:0]   nxt_item;
    logic [DEPTH_W-1:0]  depth_clamped;

    assign tick_long = item_reg.f.tick_samples > TICK_W'(MAX_TICK_SAMPLES);

    // position update, saturating at the top of the counter
    assign pos_sum     = {1'b0, pos_reg} + (POS_W+1)'(item_reg.f.tick_samples);
    assign pos_sat     = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
    assign dur_samples = POS_W'({rd_entry.duration_ms, {MS_SHIFT{1'b0}}});
    assign hit         = (rd_entry.duration_ms != '0) && (pos_sat >= dur_samples);

    always_comb begin
        if (cfg.item_count == '0) begin
            eff_cnt = COUNT_W'(1);
        end else if (cfg.item_count > COUNT_W'(MAX_ITEMS)) begin
            eff_cnt = COUNT_W'(MAX_ITEMS);
        end else begin
            eff_cnt = cfg.item_count;
        end
    end

    assign nxt_inc  = COUNT_W'(cur_reg) + COUNT_W'(1);
    assign wrap     = nxt_inc >= eff_cnt;
    assign stop     = wrap && cfg.repeat_index[REPEAT_W-1];
    assign rep_item = cfg.repeat_index[ITEM_W-1:0];

    always_comb begin
        if (!wrap) begin
            nxt_item = nxt_inc[ITEM_W-1:0];
        end else if (COUNT_W'(rep_item) < eff_cnt) begin
            nxt_item = rep_item;
        end else begin
            nxt_item = '0;
        end
    end

    assign depth_clamped = (item_reg.f.mod_depth > DEPTH_W'(DEPTH_MAX))
                         ? DEPTH_W'(DEPTH_MAX) : item_reg.f.mod_depth;

    // table access per state
    always_comb begin
        ram_req       = '0;
        ram_req.addr  = cur_reg;
        ram_req.wdata = '{first_freq:    item_reg.f.first_freq,
                          second_freq:   item_reg.f.second_freq,
                          duration_ms:   item_reg.f.duration_ms,
                          modulate_flag: item_reg.f.modulate_flag,
                          mod_depth:     depth_clamped};
        unique case (state_reg)
            ST_EXEC: begin
                if (item_reg.cmd == CMD_LOAD) begin
                    ram_req.we   = 1'b1;
                    ram_req.addr = item_reg.f.item_index;
                end else if (item_reg.cmd == CMD_TICK && !done_reg && !tick_long) begin
                    ram_req.re = 1'b1;
                end
            end
            ST_READ: begin
                ram_req.re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign emit     = (state_reg == ST_OUT) && out_free;
    assign status   = '{item: cur_reg, changed: changed_reg, done: done_reg,
                        too_long: too_long_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_reg      <= '0;
            pos_reg      <= '0;
            done_reg     <= 1'b0;
            changed_reg  <= 1'b0;
            too_long_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        item_reg     <= in_item;
                        changed_reg  <= 1'b0;
                        too_long_reg <= 1'b0;
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_READ;
                    case (item_reg.cmd)
                        CMD_START: begin
                            cur_reg     <= '0;
                            pos_reg     <= '0;
                            done_reg    <= 1'b0;
                            changed_reg <= 1'b1;
                        end
                        CMD_TICK: begin
                            if (!done_reg) begin
                                if (tick_long) begin
                                    too_long_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_TICK;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_TICK: begin
                    // entry of the sounding item is on rd_entry now
                    if (hit) begin
                        pos_reg <= '0;
                        if (stop) begin
                            done_reg <= 1'b1;
                        end else begin
                            cur_reg     <= nxt_item;
                            changed_reg <= 1'b1;
                        end
                    end else begin
                        pos_reg <= pos_sat;
                    end
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
